/* hdl/pausable_countdown_timer_bank_core_macros.svh */
// Assertion helpers, clocked on i_clk and disabled during reset.
`ifndef PAUSABLE_COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH
`define PAUSABLE_COUNTDOWN_TIMER_BANK_CORE_MACROS_SVH

// Same-cycle implication.
`define PCTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pctb_pkg.sv */
`timescale 1ns / 1ps

package pctb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SLOT_W     = 3;
    localparam int CMD_W      = 3;
    localparam int ST_W       = 2;
    localparam int TIME_W     = 32;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_IDLE  = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE   = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_ALLOC = 2'd3;

    typedef logic t_alu_op;
    localparam t_alu_op ALU_ADD  = 1'b0;
    localparam t_alu_op ALU_LEFT = 1'b1;

    // Slot store update: value write and flag write (flag write also marks allocated).
    typedef struct packed {
        logic [IDX_W-1:0]  addr;
        logic              we_val;
        logic [TIME_W-1:0] val;
        logic              we_flag;
        logic              run_flag;
    } t_bank_wr;

endpackage

/* hdl/pctb_alu.sv */
`timescale 1ns / 1ps

module pctb_alu import pctb_pkg::*; (
    input  t_alu_op           i_op,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W-1:0] o_y
);

    logic [TIME_W-1:0] sum;
    logic [TIME_W-1:0] diff;

    assign sum  = i_a + i_b;
    assign diff = i_a - i_b;

    // LEFT: wrap-safe time left, zero unless the signed difference is positive.
    always_comb begin
        case (i_op)
            ALU_ADD:  o_y = sum;
            ALU_LEFT: o_y = ((diff != '0) && !diff[TIME_W-1]) ? diff : '0;
            default:  o_y = sum;
        endcase
    end

endmodule

/* hdl/pctb_slot_bank.sv */
`timescale 1ns / 1ps

module pctb_slot_bank import pctb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_bank_wr              i_wr,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output logic [NUM_TIMERS-1:0] o_alloc,
    output logic [NUM_TIMERS-1:0] o_run,
    output logic [TIME_W-1:0]     o_rd_data
);

    // Idle slot holds its duration, running slot holds its deadline.
    logic [TIME_W-1:0]     r_val [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_alloc;
    logic [NUM_TIMERS-1:0] r_run;
    logic [TIME_W-1:0]     r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            r_run   <= '0;
        end else if (i_wr.we_flag) begin
            r_alloc[i_wr.addr] <= 1'b1;
            r_run[i_wr.addr]   <= i_wr.run_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_val) begin
            r_val[i_wr.addr] <= i_wr.val;
        end
        r_rd_data <= r_val[i_rd_addr];
    end

    assign o_alloc   = r_alloc;
    assign o_run     = r_run;
    assign o_rd_data = r_rd_data;

endmodule

/* hdl/pausable_countdown_timer_bank_core.sv */
`timescale 1ns / 1ps
// Bank of pausable countdown timers on a wrapping 32-bit millisecond counter.
// Input channel: i_in_valid / o_in_stall with i_command, i_timer_slot,
// i_time_ms, i_start_now. A transfer happens when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall with o_status, o_slot_out,
// o_remaining_ms, o_now_ms; exactly one result per input item.
// One item at a time through a small sequencer and one shared adder/compare.
// Each item goes from decode to done: tick, set, run, stop and query pass through
// execute and write-back; set on a running slot skips write-back; unused commands
// and unallocated slots go from decode straight to done; alloc scans the slots in
// order, one slot checked per cycle, 1 to 8 slots. The next transfer can come in
// the cycle after the result is loaded, not before.
// o_in_stall is high from the cycle after a transfer until the sequencer is idle.
// The result sits in an output register; while the receiver stalls, it holds
// and the next item may already be taken and processed, its result waiting
// until the output register frees up.
// Reset (synchronous, active low) clears the counter, all slot flags and the
// output valid flag; the block takes input the first cycle after reset.

module pausable_countdown_timer_bank_core import pctb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [SLOT_W-1:0] i_timer_slot,
    input  logic [TIME_W-1:0] i_time_ms,
    input  logic              i_start_now,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [TIME_W-1:0] o_remaining_ms,
    output logic [TIME_W-1:0] o_now_ms
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_WB     = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TIME_W-1:0] r_tms, n_tms;
    logic              r_start, n_start;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_alu, n_alu;
    logic [ST_W-1:0]   r_status, n_status;
    logic [SLOT_W-1:0] r_slot_out, n_slot_out;
    logic [TIME_W-1:0] r_remaining, n_remaining;
    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_o_status, n_o_status;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;
    logic [TIME_W-1:0] r_o_remaining, n_o_remaining;
    logic [TIME_W-1:0] r_o_now, n_o_now;

    t_bank_wr              bank_wr;
    logic [NUM_TIMERS-1:0] alloc_vec;
    logic [NUM_TIMERS-1:0] run_vec;
    logic [TIME_W-1:0]     rd_data;
    logic [IDX_W-1:0]      slot_idx;
    logic                  slot_ok;
    logic                  slot_run;
    t_alu_op               alu_op;
    logic [TIME_W-1:0]     alu_a;
    logic [TIME_W-1:0]     alu_b;
    logic [TIME_W-1:0]     alu_y;
    logic                  in_xfer;

    assign slot_idx = IDX_W'(r_slot);
    assign slot_ok  = (32'(r_slot) < NUM_TIMERS) && alloc_vec[slot_idx];
    assign slot_run = run_vec[slot_idx];
    assign in_xfer  = i_in_valid && !o_in_stall;

    pctb_slot_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (bank_wr),
        .i_rd_addr (slot_idx),
        .o_alloc   (alloc_vec),
        .o_run     (run_vec),
        .o_rd_data (rd_data)
    );

    pctb_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    always_comb begin
        case (r_cmd)
            CMD_TICK: begin
                alu_op = ALU_ADD;
                alu_a  = r_now;
                alu_b  = TIME_W'(1);
            end
            CMD_SET: begin
                alu_op = ALU_ADD;
                alu_a  = r_now;
                alu_b  = r_tms;
            end
            CMD_RUN: begin
                alu_op = ALU_ADD;
                alu_a  = r_now;
                alu_b  = rd_data;
            end
            CMD_STOP, CMD_QUERY: begin
                alu_op = ALU_LEFT;
                alu_a  = rd_data;
                alu_b  = r_now;
            end
            default: begin
                alu_op = ALU_ADD;
                alu_a  = r_now;
                alu_b  = '0;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_slot        = r_slot;
        n_tms         = r_tms;
        n_start       = r_start;
        n_idx         = r_idx;
        n_now         = r_now;
        n_alu         = r_alu;
        n_status      = r_status;
        n_slot_out    = r_slot_out;
        n_remaining   = r_remaining;
        n_out_valid   = r_out_valid;
        n_o_status    = r_o_status;
        n_o_slot      = r_o_slot;
        n_o_remaining = r_o_remaining;
        n_o_now       = r_o_now;
        bank_wr       = '0;
        bank_wr.addr  = slot_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd       = i_command;
                    n_slot      = i_timer_slot;
                    n_tms       = i_time_ms;
                    n_start     = i_start_now;
                    n_idx       = '0;
                    n_status    = ST_OK;
                    n_slot_out  = i_timer_slot;
                    n_remaining = '0;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_cmd)
                    CMD_TICK: n_state = S_EXEC;
                    CMD_ALLOC: n_state = S_SCAN;
                    CMD_SET, CMD_RUN, CMD_STOP, CMD_QUERY: begin
                        if (slot_ok) begin
                            n_state = S_EXEC;
                        end else begin
                            n_status = ST_NOT_ALLOC;
                            n_state  = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (!alloc_vec[r_idx]) begin
                    bank_wr.addr     = r_idx;
                    bank_wr.we_val   = 1'b1;
                    bank_wr.val      = '0;
                    bank_wr.we_flag  = 1'b1;
                    bank_wr.run_flag = 1'b0;
                    n_slot_out       = SLOT_W'(r_idx);
                    n_state          = S_DONE;
                end else if (r_idx == IDX_W'(NUM_TIMERS - 1)) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EXEC: begin
                n_alu = alu_y;
                if (r_cmd == CMD_SET && slot_run) begin
                    n_status = ST_NOT_IDLE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                case (r_cmd)
                    CMD_TICK: n_now = r_alu;
                    CMD_SET: begin
                        bank_wr.we_val   = 1'b1;
                        bank_wr.val      = r_start ? r_alu : r_tms;
                        bank_wr.we_flag  = 1'b1;
                        bank_wr.run_flag = r_start;
                    end
                    CMD_RUN: begin
                        if (!slot_run) begin
                            bank_wr.we_val   = 1'b1;
                            bank_wr.val      = r_alu;
                            bank_wr.we_flag  = 1'b1;
                            bank_wr.run_flag = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (slot_run) begin
                            bank_wr.we_val   = 1'b1;
                            bank_wr.val      = r_alu;
                            bank_wr.we_flag  = 1'b1;
                            bank_wr.run_flag = 1'b0;
                        end
                    end
                    CMD_QUERY: n_remaining = slot_run ? r_alu : rd_data;
                    default: n_remaining = '0;
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_o_status    = r_status;
                    n_o_slot      = r_slot_out;
                    n_o_remaining = r_remaining;
                    n_o_now       = r_now;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_slot        <= n_slot;
        r_tms         <= n_tms;
        r_start       <= n_start;
        r_idx         <= n_idx;
        r_alu         <= n_alu;
        r_status      <= n_status;
        r_slot_out    <= n_slot_out;
        r_remaining   <= n_remaining;
        r_o_status    <= n_o_status;
        r_o_slot      <= n_o_slot;
        r_o_remaining <= n_o_remaining;
        r_o_now       <= n_o_now;
    end

    assign o_in_stall     = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_slot_out     = r_o_slot;
    assign o_remaining_ms = r_o_remaining;
    assign o_now_ms       = r_o_now;

endmodule

/* hdl/pctb_checker.sv */
`timescale 1ns / 1ps
`include "pausable_countdown_timer_bank_core_macros.svh"

module pctb_checker import pctb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [CMD_W-1:0]  i_command,
    input logic [SLOT_W-1:0] i_timer_slot,
    input logic [TIME_W-1:0] i_time_ms,
    input logic              i_start_now,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [ST_W-1:0]   o_status,
    input logic [SLOT_W-1:0] o_slot_out,
    input logic [TIME_W-1:0] o_remaining_ms,
    input logic [TIME_W-1:0] o_now_ms
);

    `PCTB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_slot_out) && $stable(o_remaining_ms) && $stable(o_now_ms), "stalled result changed")

    `PCTB_ASSERT_NOW(a_err_no_time, o_out_valid && (o_status != ST_OK), o_remaining_ms == '0, "error result carries remaining time")

    `PCTB_ASSERT_NEXT(a_busy_after_xfer, i_in_valid && !o_in_stall, o_in_stall, "input taken while item in progress")

    `PCTB_ASSERT_NEXT(a_no_instant_result, i_in_valid && !o_in_stall && !o_out_valid, !o_out_valid, "result appeared too early")

endmodule

bind pausable_countdown_timer_bank_core pctb_checker u_pctb_checker (.*);

/* test/tb_pausable_countdown_timer_bank_core.sv */
`timescale 1ns / 1ps

module tb_pausable_countdown_timer_bank_core;
    import pctb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 30;

    localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [SLOT_W-1:0] slot_out;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] now;
    } t_timer_result;

    class timer_bank_scoreboard;
        logic [TIME_W-1:0] now_ms;
        bit                claimed  [NUM_TIMERS];
        bit                running  [NUM_TIMERS];
        logic [TIME_W-1:0] duration [NUM_TIMERS];
        logic [TIME_W-1:0] deadline [NUM_TIMERS];
        t_timer_result     expected_q[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       status_seen [4];

        function new();
            now_ms  = '0;
            errors  = 0;
            checked = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                claimed[i]  = 1'b0;
                running[i]  = 1'b0;
                duration[i] = '0;
                deadline[i] = '0;
            end
            for (int i = 0; i < 4; i++) status_seen[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // wrap-safe: time left only while (deadline - now) is strictly positive as signed
        function logic [TIME_W-1:0] time_left(logic [TIME_W-1:0] dl);
            logic [TIME_W-1:0] d;
            d = dl - now_ms;
            return (d != '0 && !d[TIME_W-1]) ? d : '0;
        endfunction

        function void start_timer(int idx);
            deadline[idx] = now_ms + duration[idx];
            running[idx]  = 1'b1;
        endfunction

        function void note_input(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                 logic [TIME_W-1:0] tms, logic start);
            t_timer_result r;
            int            idx;
            bit            found;
            r.status    = ST_OK;
            r.slot_out  = slot;
            r.remaining = '0;
            idx         = int'(slot);
            found       = 1'b0;
            if (cmd == CMD_TICK) begin
                now_ms = now_ms + 1'b1;
            end else if (cmd == CMD_ALLOC) begin
                r.status = ST_NO_FREE;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (!found && !claimed[i]) begin
                        found       = 1'b1;
                        claimed[i]  = 1'b1;
                        running[i]  = 1'b0;
                        duration[i] = '0;
                        deadline[i] = '0;
                        r.slot_out  = SLOT_W'(i);
                        r.status    = ST_OK;
                    end
                end
            end else if (cmd == CMD_SET || cmd == CMD_RUN || cmd == CMD_STOP ||
                         cmd == CMD_QUERY) begin
                if (idx >= NUM_TIMERS || !claimed[idx]) begin
                    r.status = ST_NOT_ALLOC;
                end else if (cmd == CMD_SET) begin
                    if (running[idx]) begin
                        r.status = ST_NOT_IDLE;
                    end else begin
                        duration[idx] = tms;
                        if (start) start_timer(idx);
                    end
                end else if (cmd == CMD_RUN) begin
                    if (!running[idx]) start_timer(idx);
                end else if (cmd == CMD_STOP) begin
                    if (running[idx]) begin
                        duration[idx] = time_left(deadline[idx]);
                        running[idx]  = 1'b0;
                    end
                end else begin
                    r.remaining = running[idx] ? time_left(deadline[idx]) : duration[idx];
                end
            end
            r.now = now_ms;
            expected_q.push_back(r);
        endfunction

        task report(string field, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
            $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
                     checked, field, got, want);
            errors++;
        endtask

        task check_result(logic [ST_W-1:0] status, logic [SLOT_W-1:0] slot_out,
                          logic [TIME_W-1:0] remaining, logic [TIME_W-1:0] now);
            t_timer_result e;
            if (expected_q.size() == 0) begin
                report("unexpected transfer, now_ms", now, '0);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            status_seen[e.status]++;
            if (status !== e.status)
                report("status", TIME_W'(status), TIME_W'(e.status));
            if (slot_out !== e.slot_out)
                report("slot_out", TIME_W'(slot_out), TIME_W'(e.slot_out));
            if (remaining !== e.remaining) report("remaining_ms", remaining, e.remaining);
            if (now !== e.now)             report("now_ms", now, e.now);
        endtask
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_command    = CMD_TICK;
    logic [SLOT_W-1:0] i_timer_slot = '0;
    logic [TIME_W-1:0] i_time_ms    = '0;
    logic              i_start_now  = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [ST_W-1:0]   o_status;
    logic [SLOT_W-1:0] o_slot_out;
    logic [TIME_W-1:0] o_remaining_ms;
    logic [TIME_W-1:0] o_now_ms;

    timer_bank_scoreboard sb;
    int unsigned sent        = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_hold  = 0;
    int unsigned stall_pick  = 0;
    int unsigned idle_cycles = 0;
    bit          mid_drained = 1'b0;

    pausable_countdown_timer_bank_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_timer_slot   (i_timer_slot),
        .i_time_ms      (i_time_ms),
        .i_start_now    (i_start_now),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_slot_out     (o_slot_out),
        .o_remaining_ms (o_remaining_ms),
        .o_now_ms       (o_now_ms)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(0, 6);
            end else if (stall_pick < 85) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 2);
            end else if (stall_pick < 95) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(20, 60);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_slot_out, o_remaining_ms, o_now_ms);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function int unsigned next_gap();
        int unsigned r;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [TIME_W-1:0] rand_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return TIME_W'($urandom_range(0, 24));
        if (r < 58) return '0;
        if (r < 61) return '1;
        if (r < 63) return 32'h7FFF_FFFF;
        if (r < 65) return 32'h8000_0000;
        return $urandom();
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic [TIME_W-1:0] tms, input logic start);
        int unsigned gap;
        gap = next_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_timer_slot <= slot;
        i_time_ms    <= tms;
        i_start_now  <= start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(cmd, slot, tms, start);
        sent++;
    endtask

    task automatic send_filler(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
        send_item(cmd, slot, $urandom(), 1'($urandom_range(0, 1)));
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // typical life of one timer: stop, set and usually start, let time pass, query, pause, query, resume, query
    task automatic timer_lifecycle();
        logic [SLOT_W-1:0] s;
        s = SLOT_W'($urandom_range(0, 7));
        send_filler(CMD_STOP, s);
        send_item(CMD_SET, s, TIME_W'($urandom_range(0, 12)), 1'($urandom_range(0, 3) != 0));
        repeat ($urandom_range(0, 8)) send_filler(CMD_TICK, SLOT_W'($urandom_range(0, 7)));
        send_filler(CMD_QUERY, s);
        send_filler(CMD_STOP, s);
        send_filler(CMD_QUERY, s);
        repeat ($urandom_range(0, 3)) send_filler(CMD_TICK, SLOT_W'($urandom_range(0, 7)));
        send_filler(CMD_RUN, s);
        repeat ($urandom_range(0, 8)) send_filler(CMD_TICK, SLOT_W'($urandom_range(0, 7)));
        send_filler(CMD_QUERY, s);
    endtask

    task automatic random_item();
        int unsigned      r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 30)      cmd = CMD_TICK;
        else if (r < 35) cmd = CMD_ALLOC;
        else if (r < 55) cmd = CMD_SET;
        else if (r < 68) cmd = CMD_RUN;
        else if (r < 81) cmd = CMD_STOP;
        else if (r < 96) cmd = CMD_QUERY;
        else             cmd = r[0] ? CMD_UNUSED7 : CMD_UNUSED6;
        send_item(cmd, SLOT_W'($urandom_range(0, 7)), rand_time(), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing claimed yet
        send_item(CMD_SET,   3'd0, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_RUN,   3'd7, 32'h0,         1'b0);
        send_item(CMD_STOP,  3'd3, 32'h0,         1'b0);
        send_item(CMD_QUERY, 3'd0, 32'h0,         1'b0);
        send_item(CMD_UNUSED6, 3'd5, 32'h0,       1'b0);
        send_item(CMD_UNUSED7, 3'd7, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_TICK,  3'd0, 32'h0,         1'b0);
        send_item(CMD_ALLOC, 3'd6, 32'h0,         1'b0);
        send_item(CMD_SET,   3'd0, 32'h7FFF_FFFF, 1'b0);
        send_item(CMD_QUERY, 3'd0, 32'h0,         1'b0);
        send_item(CMD_RUN,   3'd0, 32'h0,         1'b0);
        send_item(CMD_SET,   3'd0, 32'h5,         1'b1);
        send_item(CMD_RUN,   3'd0, 32'h0,         1'b0);
        send_item(CMD_TICK,  3'd0, 32'h0,         1'b0);
        send_item(CMD_QUERY, 3'd0, 32'h0,         1'b0);
        send_item(CMD_STOP,  3'd0, 32'h0,         1'b0);
        send_item(CMD_STOP,  3'd0, 32'h0,         1'b0);
        send_item(CMD_ALLOC, 3'd0, 32'h0,         1'b0);
        send_item(CMD_SET,   3'd1, 32'h1,         1'b1);
        send_item(CMD_TICK,  3'd1, 32'h0,         1'b0);
        send_item(CMD_QUERY, 3'd1, 32'h0,         1'b0);
        send_item(CMD_STOP,  3'd1, 32'h0,         1'b0);
        send_item(CMD_SET,   3'd1, 32'h8000_0000, 1'b1);
        send_item(CMD_QUERY, 3'd1, 32'h0,         1'b0);

        hold_until_drained();

        while (sent < RANDOM_ITEMS + 24) begin
            if (!mid_drained && sent >= RANDOM_ITEMS / 2) begin
                hold_until_drained();
                mid_drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 30) timer_lifecycle();
            else                            random_item();
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("results never delivered", sb.pending(), 0);

        $display("Coverage: %0d commands sent, %0d results checked, counter ended at %0d ms",
                 sent, sb.checked, sb.now_ms);
        $display("Status mix: ok %0d, not idle %0d, no free slot %0d, not allocated %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
